// File: rtl/core/fqa_pkg.sv
package fqa_pkg;

  // Word and code widths fixed by the interface.
  localparam int unsigned WordW = 32;
  localparam int unsigned OpW = 4;

  // Default number of fraction bits.
  localparam int unsigned FracBitsDefault = 8;

  // Restoring divider: quotient bits 32..0, four per stage, one in the last.
  localparam int unsigned QuotW = 33;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages = (QuotW + StepsPerStage - 1) / StepsPerStage;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_MIN    = 4'd4,
    OP_MAX    = 4'd5,
    OP_INC    = 4'd6,
    OP_DEC    = 4'd7,
    OP_TO_INT = 4'd8
  } op_e;

  // One word as it moves down the pipeline.
  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic [WordW-1:0]  r;
    logic              ovf;
    logic              dz;
    logic              neg_mul;
    logic              neg_div;
    logic [WordW-1:0]  mag_a;
    logic [63:0]       prod;
    logic [63:0]       num;
    logic [WordW-1:0]  den;
    logic [QuotW-1:0]  rem;
    logic [QuotW-1:0]  quo;
    logic              div_ovf;
  } fqa_lane_t;

endpackage

// File: rtl/core/fqa_div_stage.sv
module fqa_div_stage #(
  parameter int unsigned FirstBit = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  fqa_pkg::fqa_lane_t lane_i,
  output fqa_pkg::fqa_lane_t lane_o
);
  import fqa_pkg::*;

  // The last stage may have fewer quotient bits left than a full stage.
  localparam int unsigned Steps = (FirstBit + 1 < StepsPerStage) ? FirstBit + 1 : StepsPerStage;

  fqa_lane_t        lane_d, lane_q;
  logic [QuotW-1:0] rem_t;
  logic [QuotW-1:0] quo_t;

  // Restoring division steps for quotient bits FirstBit downward.
  always_comb begin
    lane_d = lane_i;
    rem_t  = lane_i.rem;
    quo_t  = lane_i.quo;
    for (int k = 0; k < int'(Steps); k++) begin
      rem_t = {rem_t[QuotW-2:0], lane_i.num[int'(FirstBit) - k]};
      if (rem_t >= {1'b0, lane_i.den}) begin
        rem_t = rem_t - {1'b0, lane_i.den};
        quo_t[int'(FirstBit) - k] = 1'b1;
      end
    end
    lane_d.rem = rem_t;
    lane_d.quo = quo_t;
  end

  // Stage register; holds while the pipeline is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// File: rtl/core/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU on raw 32-bit words with FRAC_BITS fraction bits.
// Request channel: req_valid_i/req_ready_o with req_type_i, operand_a_i and
// operand_b_i. Response channel: rsp_valid_o/rsp_ready_i with result_word_o,
// overflow_flag_o and divide_by_zero_flag_o. Every request gives exactly one
// response word, in order.
// From acceptance to the response, a word passes through an input
// register, an operand preparation stage, a 32x32 multiplier stage, nine
// divider stages of up to four restoring steps each, and the response
// register with rounding in front of it.
// Throughput is one word per cycle while the receiver does not stall; the
// 33-step restoring divider sets the depth of the pipeline.
// Reset clears all valid bits; the block is then empty and ready.
// When the receiver stalls, the whole pipeline holds and req_ready_o drops
// until the response word is taken; nothing is lost or repeated.
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = fqa_pkg::FracBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic [fqa_pkg::OpW-1:0]    req_type_i,
  input  logic [fqa_pkg::WordW-1:0]  operand_a_i,
  input  logic [fqa_pkg::WordW-1:0]  operand_b_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output logic [fqa_pkg::WordW-1:0]  result_word_o,
  output logic                       overflow_flag_o,
  output logic                       divide_by_zero_flag_o
);
  import fqa_pkg::*;

  localparam logic [WordW-1:0] WordMax = {1'b0, {(WordW-1){1'b1}}};
  localparam logic [WordW-1:0] WordMin = {1'b1, {(WordW-1){1'b0}}};

  typedef struct packed {
    logic              valid;
    logic [OpW-1:0]    op;
    logic [WordW-1:0]  word;
    logic              ovf;
    logic              dz;
  } out_t;

  logic              en;
  logic              in_vld_q;
  logic [OpW-1:0]    in_op_q;
  logic [WordW-1:0]  in_a_q, in_b_q;
  fqa_lane_t         prep_d, prep_q, mul_d, mul_q;
  fqa_lane_t         div_lane [DivStages+1];
  out_t              out_d, out_q;

  logic [WordW:0]    sum_ext;
  logic [WordW-1:0]  sat_sum;
  logic              sat_ovf;

  logic [63:0]       mul_rnd;
  logic              mul_sat;
  logic [QuotW:0]    div_q;
  logic              div_sat;
  fqa_lane_t         fin;

  // The pipeline moves whenever the response register is free or taken.
  assign en          = !out_q.valid || rsp_ready_i;
  assign req_ready_o = en;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      in_op_q  <= '0;
      in_a_q   <= '0;
      in_b_q   <= '0;
    end else if (en) begin
      in_vld_q <= req_valid_i;
      in_op_q  <= req_type_i;
      in_a_q   <= operand_a_i;
      in_b_q   <= operand_b_i;
    end
  end

  // Saturating add of the operation's two terms.
  always_comb begin
    sum_ext = '0;
    case (in_op_q)
      OP_ADD:  sum_ext = {in_a_q[WordW-1], in_a_q} + {in_b_q[WordW-1], in_b_q};
      OP_SUB:  sum_ext = {in_a_q[WordW-1], in_a_q} - {in_b_q[WordW-1], in_b_q};
      OP_INC:  sum_ext = {in_a_q[WordW-1], in_a_q} + (WordW+1)'(1);
      OP_DEC:  sum_ext = {in_a_q[WordW-1], in_a_q} - (WordW+1)'(1);
      default: sum_ext = '0;
    endcase
    sat_ovf = sum_ext[WordW] != sum_ext[WordW-1];
    sat_sum = sat_ovf ? (sum_ext[WordW] ? WordMin : WordMax) : sum_ext[WordW-1:0];
  end

  // Operand preparation: simple results, magnitudes and divider setup.
  always_comb begin
    prep_d         = '0;
    prep_d.valid   = in_vld_q;
    prep_d.op      = in_op_q;
    prep_d.mag_a   = in_a_q[WordW-1] ? (~in_a_q + WordW'(1)) : in_a_q;
    prep_d.den     = in_b_q[WordW-1] ? (~in_b_q + WordW'(1)) : in_b_q;
    prep_d.neg_mul = in_a_q[WordW-1] ^ in_b_q[WordW-1];
    prep_d.neg_div = in_a_q[WordW-1] ^ in_b_q[WordW-1];
    prep_d.num     = {32'd0, prep_d.mag_a} << FRAC_BITS;
    prep_d.rem     = {2'b00, prep_d.num[63:QuotW]};
    prep_d.div_ovf = {1'b0, prep_d.num[63:QuotW]} >= prep_d.den;
    prep_d.dz      = (in_op_q == OP_DIV) && (in_b_q == '0);
    case (in_op_q) inside
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        prep_d.r   = sat_sum;
        prep_d.ovf = sat_ovf;
      end
      OP_MIN:    prep_d.r = ($signed(in_a_q) < $signed(in_b_q)) ? in_a_q : in_b_q;
      OP_MAX:    prep_d.r = ($signed(in_a_q) > $signed(in_b_q)) ? in_a_q : in_b_q;
      OP_TO_INT: prep_d.r = WordW'($signed(in_a_q) >>> FRAC_BITS);
      default:   prep_d.r = '0;
    endcase
  end

  // Magnitude product.
  always_comb begin
    mul_d      = prep_q;
    mul_d.prod = 64'(prep_q.mag_a) * 64'(prep_q.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= '0;
      mul_q  <= '0;
    end else if (en) begin
      prep_q <= prep_d;
      mul_q  <= mul_d;
    end
  end

  // Divider stages, four quotient bits each, one in the last stage.
  assign div_lane[0] = mul_q;
  for (genvar g = 0; g < int'(DivStages); g++) begin : g_div
    fqa_div_stage #(
      .FirstBit(QuotW - 1 - g * StepsPerStage)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .lane_i(div_lane[g]),
      .lane_o(div_lane[g+1])
    );
  end

  // Rounding, saturation and result selection.
  always_comb begin
    fin     = div_lane[DivStages];
    mul_rnd = (fin.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mul_sat = fin.neg_mul ? (mul_rnd > 64'h8000_0000) : (mul_rnd > 64'h7FFF_FFFF);
    div_q   = {1'b0, fin.quo} + (QuotW+1)'({fin.rem, 1'b0} >= {2'b00, fin.den});
    div_sat = fin.div_ovf ||
              (fin.neg_div ? (div_q > 34'h0_8000_0000) : (div_q > 34'h0_7FFF_FFFF));
    out_d       = '0;
    out_d.valid = fin.valid;
    out_d.op    = fin.op;
    out_d.dz    = fin.dz;
    case (fin.op)
      OP_MUL: begin
        out_d.ovf = mul_sat;
        if (mul_sat) begin
          out_d.word = fin.neg_mul ? WordMin : WordMax;
        end else begin
          out_d.word = fin.neg_mul ? (~mul_rnd[WordW-1:0] + WordW'(1)) : mul_rnd[WordW-1:0];
        end
      end
      OP_DIV: begin
        if (fin.dz) begin
          out_d.word = '0;
        end else if (div_sat) begin
          out_d.ovf  = 1'b1;
          out_d.word = fin.neg_div ? WordMin : WordMax;
        end else begin
          out_d.word = fin.neg_div ? (~div_q[WordW-1:0] + WordW'(1)) : div_q[WordW-1:0];
        end
      end
      default: begin
        out_d.word = fin.r;
        out_d.ovf  = fin.ovf;
      end
    endcase
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (en) begin
      out_q <= out_d;
    end
  end

  assign rsp_valid_o           = out_q.valid;
  assign result_word_o         = out_q.word;
  assign overflow_flag_o       = out_q.ovf;
  assign divide_by_zero_flag_o = out_q.dz;

  // A divide by zero gives zero without overflow.
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && out_q.dz |-> out_q.word == '0 && !out_q.ovf)
    else $error("divide by zero word is not zero");

  // Only a divide raises the divide-by-zero flag.
  a_dz_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && out_q.dz |-> out_q.op == OP_DIV)
    else $error("divide-by-zero flag on another operation");

  // An overflow always leaves a word bound.
  a_ovf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && out_q.ovf |-> out_q.word == WordMax || out_q.word == WordMin)
    else $error("overflow without a saturated word");

  // A stall freezes the preparation stage.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(prep_q))
    else $error("pipeline moved during a stall");

endmodule

// File: dv/fixed_point_q24_8_alu_checker.sv
module fixed_point_q24_8_alu_checker #(
  parameter int unsigned FRAC_BITS = fqa_pkg::FracBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic                       req_ready_i,
  input  logic [fqa_pkg::OpW-1:0]    req_type_i,
  input  logic [fqa_pkg::WordW-1:0]  operand_a_i,
  input  logic [fqa_pkg::WordW-1:0]  operand_b_i,
  input  logic                       rsp_valid_i,
  input  logic                       rsp_ready_i,
  input  logic [fqa_pkg::WordW-1:0]  result_word_i,
  input  logic                       overflow_flag_i,
  input  logic                       divide_by_zero_flag_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import fqa_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             ovf;
    logic             dz;
  } alu_result_t;

  alu_result_t expected_q[$];

  // Clamp a wide signed value to the 32-bit word range.
  function automatic alu_result_t clamp_word(input logic signed [95:0] v, input logic dz);
    alu_result_t res;
    res.dz = dz;
    res.ovf = 1'b0;
    if (v > 96'sd2147483647) begin
      res.word = 32'h7fffffff;
      res.ovf = 1'b1;
    end else if (v < -96'sd2147483648) begin
      res.word = 32'h80000000;
      res.ovf = 1'b1;
    end else begin
      res.word = v[31:0];
    end
    return res;
  endfunction

  // Exact integer model of one ALU word, rounding products and quotients half away from zero.
  function automatic alu_result_t alu_predict(input logic [OpW-1:0] op,
                                              input logic [WordW-1:0] a_raw,
                                              input logic [WordW-1:0] b_raw);
    logic signed [95:0] a, b, p, res;
    logic [95:0] ma, mb, mp, q;
    logic neg;
    alu_result_t out;
    a = $signed(a_raw);
    b = $signed(b_raw);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    out = '0;
    case (op)
      OP_ADD: out = clamp_word(a + b, 1'b0);
      OP_SUB: out = clamp_word(a - b, 1'b0);
      OP_MUL: begin
        p = a * b;
        mp = (p < 0) ? -p : p;
        q = (mp + (96'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        res = $signed(q);
        out = clamp_word((p < 0) ? -res : res, 1'b0);
      end
      OP_DIV: begin
        if (b == 0) begin
          out.word = '0;
          out.dz = 1'b1;
        end else begin
          q = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
          neg = (a < 0) != (b < 0);
          res = $signed(q);
          out = clamp_word(neg ? -res : res, 1'b0);
        end
      end
      OP_MIN: out.word = (a < b) ? a_raw : b_raw;
      OP_MAX: out.word = (a > b) ? a_raw : b_raw;
      OP_INC: out = clamp_word(a + 1, 1'b0);
      OP_DEC: out = clamp_word(a - 1, 1'b0);
      OP_TO_INT: out.word = $signed(a_raw) >>> FRAC_BITS;
      default: out = '0;
    endcase
    return out;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // Predict on every accepted request word and compare every response word.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (req_valid_i && req_ready_i)
        expected_q.push_back(alu_predict(req_type_i, operand_a_i, operand_b_i));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", result_word_i, 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (result_word_i !== want.word)
            report_mismatch("result_word", result_word_i, want.word);
          if (overflow_flag_i !== want.ovf)
            report_mismatch("overflow_flag", overflow_flag_i, want.ovf);
          if (divide_by_zero_flag_i !== want.dz)
            report_mismatch("divide_by_zero_flag", divide_by_zero_flag_i, want.dz);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: dv/tb_fixed_point_q24_8_alu.sv
module tb_fixed_point_q24_8_alu;
  import fqa_pkg::*;

  localparam int unsigned NumRandom = 1250;
  localparam int unsigned CycleLimit = 200000;

  logic             clk_i;
  logic             rst_ni;
  logic             req_valid;
  logic             req_ready;
  logic [OpW-1:0]   req_type;
  logic [WordW-1:0] operand_a;
  logic [WordW-1:0] operand_b;
  logic             rsp_valid;
  logic             rsp_ready;
  logic [WordW-1:0] result_word;
  logic             overflow_flag;
  logic             divide_by_zero_flag;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;

  fixed_point_q24_8_alu i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .req_valid_i           (req_valid),
    .req_ready_o           (req_ready),
    .req_type_i            (req_type),
    .operand_a_i           (operand_a),
    .operand_b_i           (operand_b),
    .rsp_valid_o           (rsp_valid),
    .rsp_ready_i           (rsp_ready),
    .result_word_o         (result_word),
    .overflow_flag_o       (overflow_flag),
    .divide_by_zero_flag_o (divide_by_zero_flag)
  );

  fixed_point_q24_8_alu_checker i_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .req_valid_i           (req_valid),
    .req_ready_i           (req_ready),
    .req_type_i            (req_type),
    .operand_a_i           (operand_a),
    .operand_b_i           (operand_b),
    .rsp_valid_i           (rsp_valid),
    .rsp_ready_i           (rsp_ready),
    .result_word_i         (result_word),
    .overflow_flag_i       (overflow_flag),
    .divide_by_zero_flag_i (divide_by_zero_flag),
    .fail_count_o          (fail_count),
    .pending_o             (pending)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: one long hold-off early in the run, then stalls that rotate among always ready, random and periodic.
  initial begin
    int unsigned mode;
    rsp_ready = 1'b0;
    @(posedge rst_ni);
    repeat (40) @(negedge clk_i);
    rsp_ready <= 1'b0;
    repeat (80) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      mode = (cycle_count / 300) % 4;
      case (mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= ($urandom_range(0, 3) != 0);
        2: rsp_ready <= ($urandom_range(0, 1) != 0);
        default: rsp_ready <= ((cycle_count % 7) < 2);
      endcase
    end
  end

  // Offer one word and wait until it is taken.
  task automatic send_word(input logic [OpW-1:0] op, input logic [31:0] a,
                           input logic [31:0] b);
    req_valid <= 1'b1;
    req_type <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 2);
      1: return 32'h80000000 + $urandom_range(0, 2);
      2: return $urandom_range(0, 4) - 2;
      3: return ($urandom_range(0, 2000) - 1000) << 8;
      4: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed corners, then random words in bursts.
  initial begin
    logic [31:0] corners[6];
    int unsigned burst;
    int unsigned k;
    logic [OpW-1:0] op;
    corners = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h100, 32'h80};
    rst_ni = 1'b0;
    req_valid = 1'b0;
    req_type = '0;
    operand_a = '0;
    operand_b = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Each operation on extreme pairs, divide by zero and unknown codes.
    for (int i = 0; i <= 8; i++) begin
      send_word(op_e'(i), 32'h7fffffff, 32'h7fffffff);
      send_word(op_e'(i), 32'h80000000, 32'h80000000);
    end
    send_word(OP_DIV, 32'h00001234, 32'h0);
    send_word(OP_MUL, 32'h00000080, 32'h00000001);
    send_word(OP_MUL, 32'hffffff80, 32'h00000001);
    send_word(OP_DIV, 32'h00000001, 32'h00000200);
    send_word(OP_TO_INT, 32'hffffff01, 32'h0);
    send_word(4'd9, 32'h12345678, 32'h1);
    send_word(4'd15, 32'hffffffff, 32'hffffffff);

    k = 0;
    while (k < NumRandom) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++) begin
        if ($urandom_range(0, 19) == 0)
          op = 4'($urandom_range(9, 15));
        else
          op = 4'($urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0)
          send_word(op, corners[$urandom_range(0, 5)], corners[$urandom_range(0, 5)]);
        else if (op == OP_DIV && $urandom_range(0, 15) == 0)
          send_word(op, pick_operand(), 32'h0);
        else
          send_word(op, pick_operand(), pick_operand());
        k++;
      end
      // Gap between bursts, sometimes none.
      if ($urandom_range(0, 2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
    end
    req_valid <= 1'b0;

    // Drain, then allow the pipeline latency to pass.
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fqa_pkg.sv
rtl/core/fqa_div_stage.sv
rtl/core/fixed_point_q24_8_alu.sv
dv/fixed_point_q24_8_alu_checker.sv
dv/tb_fixed_point_q24_8_alu.sv
